[hw/rtl/lmc_pkg.sv]
// Shared types and constants for the LRU miss counter.
// No dependencies; compiled first.
package lmc_pkg;

  localparam int unsigned CfgW     = 5;
  localparam int unsigned PageW    = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DefWays  = 16;

  localparam logic [CfgW-1:0]   CapReset = CfgW'(16);
  localparam logic [CountW-1:0] MissMax  = {CountW{1'b1}};

endpackage

[hw/rtl/lmc_if.sv]
// Request and response channel interfaces for the LRU miss counter.
// Depends on lmc_pkg for the field widths.
interface lmc_req_if import lmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PageW-1:0] page;
  logic             start_of_sequence;

  modport source (output valid, output page, output start_of_sequence, input ready);
  modport sink   (input valid, input page, input start_of_sequence, output ready);
endinterface

interface lmc_rsp_if import lmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [CountW-1:0] miss_count;

  modport source (output valid, output hit, output miss_count, input ready);
  modport sink   (input valid, input hit, input miss_count, output ready);
endinterface

[hw/rtl/lru_miss_counter.sv]
// Fully associative LRU cache model that counts misses over a page request stream.
// Depends on lmc_pkg and the channel interfaces in lmc_if.sv.
//
//   channel   dir  carries                          handshake
//   req_i     in   page, start_of_sequence          valid/ready
//   rsp_o     out  hit, miss_count                  valid/ready
//   cfg       in   capacity (cfg_wdata_i)           cfg_we_i, no back-pressure
//
// One request per cycle sustained while the response is not stalled; each response
// passes through the request register, then the lookup and LRU update into the
// response register. All entries are compared in parallel.
// Reset clears valid bits, ages, counts and sets capacity to 16; page tags are
// not reset. A stalled response holds the update stage, and the request
// register then fills and drops ready.
module lru_miss_counter import lmc_pkg::*; #(
  parameter int unsigned Ways = DefWays
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  lmc_req_if.sink         req_i,
  lmc_rsp_if.source       rsp_o
);

  localparam int unsigned AgeW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned ResW = $clog2(Ways + 1);
  localparam int unsigned CmpW = (ResW > CfgW) ? ResW : CfgW;

  // configuration
  logic [CfgW-1:0] cap_q;

  // request register
  logic             req_vld_q;
  logic [PageW-1:0] page_q;
  logic             sos_q;

  // cache state
  logic [Ways-1:0]  ent_vld_q, ent_vld_d;
  logic [PageW-1:0] ent_page_q [Ways];
  logic [AgeW-1:0]  ent_age_q [Ways];
  logic [AgeW-1:0]  ent_age_d [Ways];
  logic [Ways-1:0]  ent_wr;
  logic [ResW-1:0]  res_q, res_d;
  logic [CountW-1:0] miss_q, miss_d;

  // response register
  logic              rsp_vld_q;
  logic              hit_q;
  logic [CountW-1:0] cnt_q;

  logic              adv;
  logic [Ways-1:0]   vld_cur, match, free_oh, victim;
  logic [ResW-1:0]   res_cur;
  logic [CountW-1:0] miss_cur;
  logic [CmpW-1:0]   cap_eff;
  logic              cap_zero, full, hit;
  logic [AgeW-1:0]   hit_age, oldest;

  assign adv         = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      req_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      page_q <= req_i.page;
      sos_q  <= req_i.start_of_sequence;
    end
  end

  always_comb begin
    // start of sequence: treat the cache as empty for this request
    vld_cur  = sos_q ? '0 : ent_vld_q;
    res_cur  = sos_q ? '0 : res_q;
    miss_cur = sos_q ? '0 : miss_q;

    cap_eff  = (CmpW'(cap_q) > CmpW'(Ways)) ? CmpW'(Ways) : CmpW'(cap_q);
    cap_zero = (cap_eff == '0);
    full     = (CmpW'(res_cur) >= cap_eff);
    oldest   = AgeW'(res_cur - ResW'(1));

    hit_age = '0;
    for (int i = 0; i < Ways; i++) begin
      match[i]  = vld_cur[i] && (ent_page_q[i] == page_q) && !cap_zero;
      victim[i] = vld_cur[i] && (ent_age_q[i] == oldest);
      hit_age   = hit_age | (match[i] ? ent_age_q[i] : '0);
    end
    hit = |match;

    // lowest invalid entry
    free_oh = ~vld_cur & (vld_cur + Ways'(1));

    ent_vld_d = vld_cur;
    ent_wr    = '0;
    res_d     = res_cur;
    for (int i = 0; i < Ways; i++) begin
      ent_age_d[i] = ent_age_q[i];
      if (hit) begin
        if (match[i]) begin
          ent_age_d[i] = '0;
        end else if (vld_cur[i] && ent_age_q[i] < hit_age) begin
          ent_age_d[i] = ent_age_q[i] + AgeW'(1);
        end
      end else if (!cap_zero) begin
        if (full) begin
          // replace the least recent entry
          if (victim[i]) begin
            ent_wr[i]    = 1'b1;
            ent_age_d[i] = '0;
          end else if (vld_cur[i] && ent_age_q[i] < oldest) begin
            ent_age_d[i] = ent_age_q[i] + AgeW'(1);
          end
        end else begin
          if (free_oh[i]) begin
            ent_wr[i]    = 1'b1;
            ent_vld_d[i] = 1'b1;
            ent_age_d[i] = '0;
          end else if (vld_cur[i]) begin
            ent_age_d[i] = ent_age_q[i] + AgeW'(1);
          end
        end
      end
    end
    if (!hit && !cap_zero && !full) begin
      res_d = res_cur + ResW'(1);
    end

    miss_d = miss_cur;
    if (!hit && miss_cur != MissMax) begin
      miss_d = miss_cur + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      res_q     <= '0;
      miss_q    <= '0;
      for (int i = 0; i < Ways; i++) begin
        ent_age_q[i] <= '0;
      end
    end else if (adv) begin
      ent_vld_q <= ent_vld_d;
      res_q     <= res_d;
      miss_q    <= miss_d;
      for (int i = 0; i < Ways; i++) begin
        ent_age_q[i] <= ent_age_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Ways; i++) begin
      if (adv && ent_wr[i]) begin
        ent_page_q[i] <= page_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (adv) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= hit;
      cnt_q <= miss_d;
    end
  end

  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.miss_count = cnt_q;

endmodule

[hw/rtl/lmc_checker.sv]
// Port-level assertions for the LRU miss counter, bound to its top level.
// Depends on lmc_pkg and lru_miss_counter.
module lmc_checker import lmc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic [CfgW-1:0]   cfg_wdata_i,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_hit_i,
  input logic [CountW-1:0] rsp_miss_count_i
);

  logic [CfgW-1:0] cap_q;
  logic [2:0]      pend_q;
  logic            req_acc, rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(req_acc) - 3'(rsp_acc);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_hit_i) && $stable(rsp_miss_count_i))
    else $error("response changed while stalled");

  a_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("more than two requests in flight");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pend_q != 3'd0)
    else $error("response without a pending request");

  a_cap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && cap_q == '0 |-> !rsp_hit_i)
    else $error("hit reported with capacity zero");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd2 && rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("request taken while both stages are full and stalled");

endmodule

bind lru_miss_counter lmc_checker u_lmc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_we_i         (cfg_we_i),
  .cfg_wdata_i      (cfg_wdata_i),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_hit_i        (rsp_o.hit),
  .rsp_miss_count_i (rsp_o.miss_count)
);

[tb/sv/tb_lru_miss_counter.sv]
`timescale 1ns / 100ps
// Testbench for lru_miss_counter: a directed table, random page streams per capacity, then a ring of three pages.
// Depends on lmc_pkg, lmc_if.sv and the lru_miss_counter RTL.
module tb_lru_miss_counter;
  import lmc_pkg::*;

  localparam int unsigned Ways       = DefWays;
  localparam int          StallLimit = 2000;
  localparam int          RingRefs   = 12;

  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] miss_count;
  } lookup_t;

  typedef enum bit {ROW_REF, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CfgW-1:0]   cap;
    logic [PageW-1:0]  page;
    logic              sos;
    bit                typed;
    logic              hit;
    logic [CountW-1:0] count;
  } walk_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  lmc_req_if req_bus ();
  lmc_rsp_if rsp_bus ();

  lru_miss_counter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  always #5ns clk_i = ~clk_i;

  // Cache image kept alongside the block
  logic [PageW-1:0]  tag_q [Ways];
  bit                live_q [Ways];
  int unsigned       age_q [Ways];
  int unsigned       resident_q;
  logic [CountW-1:0] misses_q;
  logic [CfgW-1:0]   cap_q;

  lookup_t pending_lookups [$];
  int      mismatch_count;
  int      responses_seen;
  int      hold_left;
  bit      hold_done;
  bit      gaps_on;
  int      quiet_cycles;

  // Capacity lowered mid-sequence, capacity zero and capacity above the way count included
  walk_row_t walk_table [19] = '{
    '{ROW_REF, 5'd0,  16'h0000, 1'b1, 1'b1, 1'b0, 16'd1},
    '{ROW_REF, 5'd0,  16'h0000, 1'b0, 1'b1, 1'b1, 16'd1},
    '{ROW_REF, 5'd0,  16'hFFFF, 1'b0, 1'b1, 1'b0, 16'd2},
    '{ROW_REF, 5'd0,  16'hAAAA, 1'b0, 1'b1, 1'b0, 16'd3},
    '{ROW_REF, 5'd0,  16'h5555, 1'b0, 1'b1, 1'b0, 16'd4},
    '{ROW_REF, 5'd0,  16'hFFFF, 1'b0, 1'b1, 1'b1, 16'd4},
    '{ROW_CFG, 5'd2,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_REF, 5'd0,  16'h0000, 1'b0, 1'b1, 1'b1, 16'd4},
    '{ROW_REF, 5'd0,  16'h1234, 1'b0, 1'b1, 1'b0, 16'd5},
    '{ROW_REF, 5'd0,  16'hAAAA, 1'b0, 1'b1, 1'b0, 16'd6},
    '{ROW_REF, 5'd0,  16'h5555, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG, 5'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_REF, 5'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_REF, 5'd0,  16'h0000, 1'b1, 1'b1, 1'b0, 16'd1},
    '{ROW_CFG, 5'd31, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_REF, 5'd0,  16'h0001, 1'b1, 1'b1, 1'b0, 16'd1},
    '{ROW_CFG, 5'd1,  16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_REF, 5'd0,  16'h0001, 1'b0, 1'b1, 1'b1, 16'd1},
    '{ROW_REF, 5'd0,  16'h0002, 1'b0, 1'b1, 1'b0, 16'd2}
  };

  function automatic void clear_cache();
    for (int i = 0; i < Ways; i++) begin
      tag_q[i]  = '0;
      live_q[i] = 1'b0;
      age_q[i]  = 0;
    end
    resident_q = 0;
    misses_q   = '0;
  endfunction

  function automatic void age_below(input int unsigned limit);
    for (int i = 0; i < Ways; i++) begin
      if (live_q[i] && age_q[i] < limit) age_q[i]++;
    end
  endfunction

  function automatic lookup_t lru_lookup(input logic [PageW-1:0] pg, input logic sos);
    int unsigned in_use;
    int          found;
    int          slot;
    int unsigned oldest;
    lookup_t     res;
    in_use = (cap_q > Ways) ? Ways : cap_q;
    found  = -1;
    slot   = -1;
    oldest = 0;
    if (sos) clear_cache();
    if (in_use > 0) begin
      for (int i = 0; i < Ways; i++) begin
        if (found < 0 && live_q[i] && tag_q[i] == pg) found = i;
      end
    end
    if (found >= 0) begin
      age_below(age_q[found]);
      age_q[found] = 0;
    end else begin
      if (misses_q != MissMax) misses_q++;
      if (in_use > 0) begin
        if (resident_q >= in_use) begin
          // replace the least recent entry
          for (int i = 0; i < Ways; i++) begin
            if (live_q[i] && (slot < 0 || age_q[i] > oldest)) begin
              slot   = i;
              oldest = age_q[i];
            end
          end
          if (slot >= 0) begin
            age_below(oldest);
            tag_q[slot] = pg;
            age_q[slot] = 0;
          end
        end else begin
          for (int i = 0; i < Ways; i++) begin
            if (slot < 0 && !live_q[i]) slot = i;
          end
          if (slot >= 0) begin
            age_below(32'hFFFF_FFFF);
            tag_q[slot]  = pg;
            live_q[slot] = 1'b1;
            age_q[slot]  = 0;
            resident_q++;
          end
        end
      end
    end
    res.hit        = (found >= 0);
    res.miss_count = misses_q;
    return res;
  endfunction

  // Offer one request, hold it until taken, then log what it should return
  task automatic issue_ref(input logic [PageW-1:0] pg, input logic sos,
                           input bit typed, input lookup_t typed_want);
    int      gap;
    lookup_t predicted;
    gap = 0;
    if (gaps_on) begin
      while ($urandom_range(99) < 7) gap++;
    end
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid             <= 1'b1;
    req_bus.page              <= pg;
    req_bus.start_of_sequence <= sos;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predicted = lru_lookup(pg, sos);
    pending_lookups = {pending_lookups, (typed ? typed_want : predicted)};
  endtask

  // Capacity changes only once every outstanding response is back
  task automatic write_capacity(input logic [CfgW-1:0] cap);
    req_bus.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_q = cap;
  endtask

  // Response side: check, then pick next ready
  initial begin
    lookup_t want;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) begin
        responses_seen++;
        if (pending_lookups.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected response: hit=%0b miss_count=%0d",
                     rsp_bus.hit, rsp_bus.miss_count);
        end else begin
          want = pending_lookups.pop_front();
          if (rsp_bus.hit !== want.hit || rsp_bus.miss_count !== want.miss_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("response %0d: expected hit=%0b miss_count=%0d, %s=%0b miss_count=%0d",
                       responses_seen, want.hit, want.miss_count, "got hit",
                       rsp_bus.hit, rsp_bus.miss_count);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (responses_seen == 150 && !hold_done) begin
        // hold off long enough for the block to back up into its input
        hold_done = 1'b1;
        hold_left = 300;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= !(gaps_on && $urandom_range(99) < 7);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [PageW-1:0] page_pool [$];
    logic [PageW-1:0] ring [3];
    logic [PageW-1:0] pg;
    logic [CfgW-1:0]  cap;
    int unsigned      in_use;
    int               pool_size;
    int               phase_refs;
    lookup_t          typed_want;
    mismatch_count = 0;
    responses_seen = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    gaps_on        = 1'b1;
    quiet_cycles   = 0;
    rst_ni                    <= 1'b0;
    cfg_we_i                  <= 1'b0;
    cfg_wdata_i               <= '0;
    req_bus.valid             <= 1'b0;
    req_bus.page              <= '0;
    req_bus.start_of_sequence <= 1'b0;
    rsp_bus.ready             <= 1'b0;
    clear_cache();
    cap_q = CapReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (walk_table[r]) begin
      if (walk_table[r].kind == ROW_CFG) begin
        write_capacity(walk_table[r].cap);
      end else begin
        typed_want.hit        = walk_table[r].hit;
        typed_want.miss_count = walk_table[r].count;
        issue_ref(walk_table[r].page, walk_table[r].sos, walk_table[r].typed, typed_want);
      end
    end

    // Random phases: a page pool sized around the capacity gives hits and evictions
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       cap = 5'd16;
        1:       cap = 5'd3;
        2:       cap = 5'd0;
        3:       cap = 5'd31;
        4:       cap = 5'd1;
        default: cap = 5'($urandom_range(31));
      endcase
      write_capacity(cap);
      in_use    = (cap > Ways) ? Ways : cap;
      pool_size = $urandom_range(1, in_use + 4);
      page_pool.delete();
      repeat (pool_size) page_pool = {page_pool, PageW'($urandom)};
      gaps_on    = (ph != 5);
      phase_refs = (ph == 5) ? 80 : 30;
      for (int n = 0; n < phase_refs; n++) begin
        if ($urandom_range(99) < 10) pg = PageW'($urandom);
        else                         pg = page_pool[$urandom_range(pool_size - 1)];
        issue_ref(pg, (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3),
                  1'b0, '0);
      end
    end
    gaps_on = 1'b1;

    // Three pages round a two-entry cache always miss
    write_capacity(5'd2);
    ring[0] = PageW'($urandom);
    ring[1] = ring[0] + 1'b1;
    ring[2] = ring[0] + 2'd2;
    for (int n = 0; n < RingRefs; n++) issue_ref(ring[2'(n % 3)], n == 0, 1'b0, '0);
    issue_ref(ring[0], 1'b1, 1'b0, '0);
    issue_ref(ring[0], 1'b0, 1'b0, '0);

    req_bus.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
